### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked property, held off while reset is asserted
`define IMH_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// checked property, always on
`define IMH_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define IMH_ASSERT(lbl, clk, rstn, prop, msg)
`define IMH_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### rtl/imh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_pkg
// Types and codes of the indexed min-heap block.
// ----------------------------------------------------------------------------
package imh_pkg;

    localparam int HEAP_CAPACITY = 8192;
    localparam int AXIS_SIZE     = 32;
    localparam int KEY_BITS      = 16;

    localparam logic [1:0] ACT_INSERT   = 2'd0;
    localparam logic [1:0] ACT_POP      = 2'd1;
    localparam logic [1:0] ACT_DECREASE = 2'd2;
    localparam logic [1:0] ACT_REMOVE   = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_EMPTY   = 2'd2;
    localparam logic [1:0] ST_ABSENT  = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] key_value;
        logic [4:0]  coord_x;
        logic [4:0]  coord_y;
        logic [4:0]  coord_z;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] popped_key;
        logic [4:0]  popped_x;
        logic [4:0]  popped_y;
        logic [4:0]  popped_z;
        logic [13:0] entry_total;
    } out_item_t;

    typedef struct packed {
        logic [4:0] x;
        logic [4:0] y;
        logic [4:0] z;
    } crd_t;

    localparam int CRD_BITS = $bits(crd_t);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_CHECK,
        S_MOVE,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_DONE
    } state_t;

endpackage

### rtl/imh_slot_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_slot_ram
// Heap slot store: key and point per slot, one write and two registered reads.
// ----------------------------------------------------------------------------
module imh_slot_ram #(
    parameter int AW    = 14,
    parameter int DW    = 31,
    parameter int DEPTH = 8193
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr_a,
    output logic [DW-1:0] rdata_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### rtl/imh_pos_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imh_pos_ram
// Back-pointer store: heap slot of every grid point, one write, one read.
// ----------------------------------------------------------------------------
module imh_pos_ram #(
    parameter int AW    = 15,
    parameter int DW    = 14,
    parameter int DEPTH = 32768
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/indexed_min_heap_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_min_heap_top
// Indexed binary min-heap with decrease-key and remove of a named point.
// ----------------------------------------------------------------------------
// One item is worked at a time. After reset the back-pointer memory is cleared
// by a pass of one write per grid point with s_ready low. An accepted item has
// its point's slot looked up in the back-pointer memory and then read from the
// slot memory. At each heap level a sift reads the slot memory and then
// compares and writes back (a sift up that starts at the root only writes),
// and the result is handed off last. The hand off waits while an earlier
// result has not yet been taken by the receiver. A pointer is trusted only if
// it is inside the fill count and the slot it names holds that same point, so
// removal leaves the old pointer in place.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module indexed_min_heap_top
    import imh_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam int AW = $clog2(HEAP_CAPACITY + 1);
    localparam int PC = AXIS_SIZE * AXIS_SIZE * AXIS_SIZE;
    localparam int PW = $clog2(PC);
    localparam int HW = KEY_BITS + CRD_BITS;

    function automatic logic [KEY_BITS-1:0] key_of(input logic [HW-1:0] e);
        return e[HW-1 -: KEY_BITS];
    endfunction

    function automatic crd_t crd_of(input logic [HW-1:0] e);
        return crd_t'(e[CRD_BITS-1:0]);
    endfunction

    function automatic logic [PW-1:0] pt_of(input crd_t c);
        return PW'((int'(c.z) * AXIS_SIZE + int'(c.y)) * AXIS_SIZE + int'(c.x));
    endfunction

    state_t            state_reg, state_next;
    logic [PW-1:0]     clr_reg, clr_next;
    logic [1:0]        act_reg, act_next;
    logic [KEY_BITS-1:0] key_reg, key_next;
    crd_t              crd_reg, crd_next;
    logic [AW-1:0]     slot_reg, slot_next;
    logic [HW-1:0]     min_reg, min_next;
    logic [HW-1:0]     cur_reg, cur_next;
    logic [AW-1:0]     k_reg, k_next;
    logic [AW-1:0]     hole_reg, hole_next;
    logic              down_reg, down_next;
    logic [AW-1:0]     cnt_reg, cnt_next;
    logic [1:0]        status_reg, status_next;
    out_item_t         out_reg, out_next;
    logic              m_valid_reg, m_valid_next;

    logic          hp_we;
    logic [AW-1:0] hp_wa, hp_ra, hp_rb;
    logic [HW-1:0] hp_wd, hp_rd_a, hp_rd_b;
    logic          pos_we;
    logic [PW-1:0] pos_wa, pos_ra;
    logic [AW-1:0] pos_wd, pos_rd;

    crd_t          crd_in;
    logic          present;
    logic [AW-1:0] j_addr;
    logic [HW-1:0] child;
    logic [AW-1:0] child_k;
    logic [KEY_BITS-1:0] new_key;

    imh_slot_ram #(.AW(AW), .DW(HW), .DEPTH(HEAP_CAPACITY + 1)) u_slot_ram (
        .aclk    (aclk),
        .we      (hp_we),
        .waddr   (hp_wa),
        .wdata   (hp_wd),
        .raddr_a (hp_ra),
        .rdata_a (hp_rd_a),
        .raddr_b (hp_rb),
        .rdata_b (hp_rd_b)
    );

    imh_pos_ram #(.AW(PW), .DW(AW), .DEPTH(PC)) u_pos_ram (
        .aclk  (aclk),
        .we    (pos_we),
        .waddr (pos_wa),
        .wdata (pos_wd),
        .raddr (pos_ra),
        .rdata (pos_rd)
    );

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        crd_in.x = 5'(int'(s_data.coord_x) % AXIS_SIZE);
        crd_in.y = 5'(int'(s_data.coord_y) % AXIS_SIZE);
        crd_in.z = 5'(int'(s_data.coord_z) % AXIS_SIZE);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        act_reg    <= act_next;
        key_reg    <= key_next;
        crd_reg    <= crd_next;
        slot_reg   <= slot_next;
        min_reg    <= min_next;
        cur_reg    <= cur_next;
        k_reg      <= k_next;
        hole_reg   <= hole_next;
        down_reg   <= down_next;
        status_reg <= status_next;
        out_reg    <= out_next;
    end

    always_comb begin
        state_next   = state_reg;
        clr_next     = clr_reg;
        act_next     = act_reg;
        key_next     = key_reg;
        crd_next     = crd_reg;
        slot_next    = slot_reg;
        min_next     = min_reg;
        cur_next     = cur_reg;
        k_next       = k_reg;
        hole_next    = hole_reg;
        down_next    = down_reg;
        cnt_next     = cnt_reg;
        status_next  = status_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;

        hp_we  = 1'b0;
        hp_wa  = k_reg;
        hp_wd  = cur_reg;
        hp_ra  = AW'(1);
        hp_rb  = AW'(1);
        pos_we = 1'b0;
        pos_wa = pt_of(crd_of(cur_reg));
        pos_wd = k_reg;
        pos_ra = pt_of(crd_in);

        present = (slot_reg != '0) && (slot_reg <= cnt_reg) && (crd_of(hp_rd_a) == crd_reg);
        new_key = (key_reg < key_of(hp_rd_a)) ? key_reg : key_of(hp_rd_a);
        j_addr  = AW'({k_reg, 1'b0});
        if ((j_addr < cnt_reg) && (key_of(hp_rd_a) > key_of(hp_rd_b))) begin
            child   = hp_rd_b;
            child_k = j_addr + AW'(1);
        end else begin
            child   = hp_rd_a;
            child_k = j_addr;
        end

        case (state_reg)
            S_CLEAR: begin
                // every grid point starts absent
                pos_we   = 1'b1;
                pos_wa   = clr_reg;
                pos_wd   = '0;
                clr_next = clr_reg + PW'(1);
                if (clr_reg == PW'(PC - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    act_next   = s_data.action;
                    key_next   = KEY_BITS'(s_data.key_value);
                    crd_next   = crd_in;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                // slot 1 read in idle is the current minimum
                min_next   = hp_rd_a;
                slot_next  = pos_rd;
                hp_ra      = pos_rd;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                status_next = ST_OK;
                hole_next   = slot_reg;
                case (act_reg)
                    ACT_POP, ACT_REMOVE: begin
                        if (act_reg == ACT_POP && cnt_reg == '0) begin
                            status_next = ST_EMPTY;
                            state_next  = S_DONE;
                        end else if (act_reg == ACT_REMOVE && !present) begin
                            status_next = ST_ABSENT;
                            state_next  = S_DONE;
                        end else begin
                            if (act_reg == ACT_POP) begin
                                hole_next = AW'(1);
                            end
                            cnt_next = cnt_reg - AW'(1);
                            // last entry refills the hole unless it is the hole
                            if (hole_next == cnt_reg) begin
                                state_next = S_DONE;
                            end else begin
                                hp_ra      = cnt_reg;
                                state_next = S_MOVE;
                            end
                        end
                    end
                    default: begin
                        down_next = 1'b0;
                        if (present) begin
                            cur_next   = {new_key, crd_reg};
                            k_next     = slot_reg;
                            state_next = S_UP_RD;
                        end else if (act_reg == ACT_DECREASE) begin
                            status_next = ST_ABSENT;
                            state_next  = S_DONE;
                        end else if (cnt_reg >= AW'(HEAP_CAPACITY)) begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end else begin
                            cnt_next   = cnt_reg + AW'(1);
                            cur_next   = {key_reg, crd_reg};
                            k_next     = cnt_reg + AW'(1);
                            state_next = S_UP_RD;
                        end
                    end
                endcase
            end
            S_MOVE: begin
                cur_next   = hp_rd_a;
                k_next     = hole_reg;
                down_next  = 1'b1;
                state_next = S_UP_RD;
            end
            S_UP_RD: begin
                if (k_reg == AW'(1)) begin
                    hp_we      = 1'b1;
                    pos_we     = 1'b1;
                    state_next = down_reg ? S_DN_RD : S_DONE;
                end else begin
                    hp_ra      = k_reg >> 1;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                if (key_of(hp_rd_a) > key_of(cur_reg)) begin
                    hp_we      = 1'b1;
                    hp_wd      = hp_rd_a;
                    pos_we     = 1'b1;
                    pos_wa     = pt_of(crd_of(hp_rd_a));
                    k_next     = k_reg >> 1;
                    state_next = S_UP_RD;
                end else begin
                    hp_we      = 1'b1;
                    pos_we     = 1'b1;
                    state_next = down_reg ? S_DN_RD : S_DONE;
                end
            end
            S_DN_RD: begin
                if (k_reg > (cnt_reg >> 1)) begin
                    hp_we      = 1'b1;
                    pos_we     = 1'b1;
                    state_next = S_DONE;
                end else begin
                    hp_ra      = j_addr;
                    hp_rb      = j_addr + AW'(1);
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP: begin
                if (key_of(cur_reg) <= key_of(child)) begin
                    hp_we      = 1'b1;
                    pos_we     = 1'b1;
                    state_next = S_DONE;
                end else begin
                    hp_we      = 1'b1;
                    hp_wd      = child;
                    pos_we     = 1'b1;
                    pos_wa     = pt_of(crd_of(child));
                    k_next     = child_k;
                    state_next = S_DN_RD;
                end
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.status      = status_reg;
                    out_next.popped_key  = '0;
                    out_next.popped_x    = '0;
                    out_next.popped_y    = '0;
                    out_next.popped_z    = '0;
                    out_next.entry_total = 14'(cnt_reg);
                    if (act_reg == ACT_POP && status_reg == ST_OK) begin
                        out_next.popped_key = 16'(key_of(min_reg));
                        out_next.popped_x   = crd_of(min_reg).x;
                        out_next.popped_y   = crd_of(min_reg).y;
                        out_next.popped_z   = crd_of(min_reg).z;
                    end
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    `IMH_ASSERT(a_cnt_bound, aclk, aresetn, cnt_reg <= AW'(HEAP_CAPACITY), "fill count over capacity")
    `IMH_ASSERT(a_accept_look, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == S_LOOK), "accepted item not looked up")
    `IMH_ASSERT(a_write_range, aclk, aresetn, hp_we |-> (hp_wa != '0 && hp_wa <= cnt_reg), "heap write outside filled slots")
    `IMH_ASSERT(a_full_total, aclk, aresetn, (m_valid && m_data.status == ST_FULL) |-> (m_data.entry_total == 14'(HEAP_CAPACITY)), "full status with room left")

endmodule
